[sv/dmpsc_pkg.sv]
package dmpsc_pkg;

    // Drive saturation in PWM steps; the drive limit is this times unit_div.
    localparam int DRIVE_LIMIT_STEPS = 255;

    localparam int DIV_W    = 8;
    localparam int QUO_W    = $clog2(DRIVE_LIMIT_STEPS + 1);
    localparam int DVD_W    = DIV_W + QUO_W;
    localparam int LIM_W    = $clog2(DRIVE_LIMIT_STEPS * 255 + 1);
    localparam int DRV_W    = LIM_W + 1;
    localparam int CNT_W    = (QUO_W > 1) ? $clog2(QUO_W) : 1;

    localparam int TGT_W    = 13;
    localparam int GAIN_W   = 9;
    localparam int PV_W     = 9;
    localparam int ERR_W    = 14;
    localparam int DIFF_W   = 15;
    localparam int INT_W    = 32;
    localparam int PROD_W   = INT_W + GAIN_W;
    localparam int ACC_W    = PROD_W + 3;

    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BIAS   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KI     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KD     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIV    = 3'd5;

    localparam logic [2:0] MUL_KP_R = 3'd0;
    localparam logic [2:0] MUL_KD_R = 3'd1;
    localparam logic [2:0] MUL_KP_L = 3'd2;
    localparam logic [2:0] MUL_KD_L = 3'd3;
    localparam logic [2:0] MUL_KI   = 3'd4;

    localparam logic [2:0] ACC_NONE = 3'd0;
    localparam logic [2:0] ACC_LOAD = 3'd1;
    localparam logic [2:0] ACC_R    = 3'd2;
    localparam logic [2:0] ACC_L    = 3'd3;
    localparam logic [2:0] ACC_SYNC = 3'd4;

    typedef struct packed {
        logic [7:0] right_count;
        logic       right_backward;
        logic [7:0] left_count;
        logic       left_backward;
    } t_in_item;

    typedef struct packed {
        logic       right_reverse;
        logic [7:0] right_duty;
        logic       left_reverse;
        logic [7:0] left_duty;
    } t_out_item;

    typedef struct packed {
        logic signed [TGT_W-1:0]  speed_target;
        logic signed [TGT_W-1:0]  steer_bias;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [DIV_W-1:0]         unit_div;
    } t_cfg;

    typedef struct packed {
        logic       load_in;
        logic       calc_err;
        logic [2:0] mul_sel;
        logic [2:0] acc_op;
        logic       clamp;
        logic       div_start;
        logic       div_left;
        logic       cap_r;
        logic       cap_l;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

[sv/dmpsc_cfg.sv]
module dmpsc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dmpsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dmpsc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dmpsc_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    output dmpsc_pkg::t_cfg                o_cfg
);
    import dmpsc_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_target <= '0;
            r_cfg.steer_bias   <= '0;
            r_cfg.gain_p       <= GAIN_W'(50);
            r_cfg.gain_i       <= GAIN_W'(1);
            r_cfg.gain_d       <= GAIN_W'(40);
            r_cfg.unit_div     <= DIV_W'(50);
        end else if (wr) begin
            unique case (idx)
                REG_TARGET: r_cfg.speed_target <= $signed(pwdata[TGT_W-1:0]);
                REG_BIAS:   r_cfg.steer_bias   <= $signed(pwdata[TGT_W-1:0]);
                REG_KP:     r_cfg.gain_p       <= $signed(pwdata[GAIN_W-1:0]);
                REG_KI:     r_cfg.gain_i       <= $signed(pwdata[GAIN_W-1:0]);
                REG_KD:     r_cfg.gain_d       <= $signed(pwdata[GAIN_W-1:0]);
                REG_DIV:    r_cfg.unit_div     <= pwdata[DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TARGET: prdata = PDATA_W'($unsigned(r_cfg.speed_target));
            REG_BIAS:   prdata = PDATA_W'($unsigned(r_cfg.steer_bias));
            REG_KP:     prdata = PDATA_W'($unsigned(r_cfg.gain_p));
            REG_KI:     prdata = PDATA_W'($unsigned(r_cfg.gain_i));
            REG_KD:     prdata = PDATA_W'($unsigned(r_cfg.gain_d));
            REG_DIV:    prdata = PDATA_W'(r_cfg.unit_div);
            default:    prdata = '0;
        endcase
    end

endmodule

[sv/dmpsc_div.sv]
module dmpsc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dmpsc_pkg::DVD_W-1:0]   i_dividend,
    input  logic [dmpsc_pkg::DIV_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [dmpsc_pkg::QUO_W-1:0]   o_quo
);
    import dmpsc_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dsr;
    logic [QUO_W-1:0] r_quo;
    logic [DVD_W:0]   trial;

    // Restoring division, one quotient bit per cycle, divisor pre-shifted.
    assign trial = {1'b0, r_rem} - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsr <= DVD_W'(i_divisor) << (QUO_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (!trial[DVD_W]) begin
                r_rem <= trial[DVD_W-1:0];
            end
            r_dsr <= r_dsr >> 1;
            r_quo <= {r_quo[QUO_W-2:0], !trial[DVD_W]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && !r_done))
        else $error("divider not running after start");

endmodule

[sv/dmpsc_datapath.sv]
module dmpsc_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dmpsc_pkg::t_cfg        i_cfg,
    input  dmpsc_pkg::t_in_item    i_in_data,
    input  dmpsc_pkg::t_cmd        i_cmd,
    output dmpsc_pkg::t_status     o_status,
    output dmpsc_pkg::t_out_item   o_out_data
);
    import dmpsc_pkg::*;

    logic signed [PV_W-1:0]   r_pv_r, r_pv_l;
    logic signed [ERR_W-1:0]  r_err_r, r_err_l;
    logic signed [ERR_W-1:0]  r_last_r, r_last_l;
    logic signed [DIFF_W-1:0] r_diff_r, r_diff_l;
    logic signed [INT_W-1:0]  r_integ;
    logic signed [DRV_W-1:0]  r_drive_r, r_drive_l;
    logic [LIM_W-1:0]         r_lim;
    logic [DIV_W-1:0]         r_div;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc_r, r_acc_l;
    logic [QUO_W-1:0]         r_q_r;
    t_out_item                r_out;

    logic signed [PV_W-1:0]   n_pv_r, n_pv_l;
    logic [DIV_W-1:0]         n_div;
    logic signed [INT_W-1:0]  bias_term;
    logic signed [INT_W-1:0]  mul_a;
    logic signed [GAIN_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  lim_pos, lim_neg;
    logic signed [DRV_W-1:0]  mag_r, mag_l, mag_sel;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;

    function automatic logic [7:0] duty_of(logic [QUO_W-1:0] q, logic rev);
        int d;
        d = rev ? 255 - int'(q) : int'(q);
        if (d > 255) d = 255;
        if (d < 0) d = 0;
        return 8'(d);
    endfunction

    assign n_pv_r = i_in_data.right_backward ? -$signed({1'b0, i_in_data.right_count})
                                             :  $signed({1'b0, i_in_data.right_count});
    assign n_pv_l = i_in_data.left_backward ? -$signed({1'b0, i_in_data.left_count})
                                            :  $signed({1'b0, i_in_data.left_count});
    assign n_div  = (i_cfg.unit_div == '0) ? DIV_W'(1) : i_cfg.unit_div;

    // Steering bias follows the sign of the target.
    assign bias_term = (i_cfg.speed_target >= 0) ?  INT_W'(i_cfg.steer_bias)
                                                 : -INT_W'(i_cfg.steer_bias);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pv_r <= n_pv_r;
            r_pv_l <= n_pv_l;
        end
        if (i_cmd.calc_err) begin
            r_err_r <= ERR_W'(i_cfg.speed_target) - ERR_W'(r_pv_r);
            r_err_l <= ERR_W'(i_cfg.speed_target) - ERR_W'(r_pv_l);
            r_div   <= n_div;
            r_lim   <= LIM_W'(DRIVE_LIMIT_STEPS * int'(n_div));
        end
        r_diff_r <= DIFF_W'(r_err_r) - DIFF_W'(r_last_r);
        r_diff_l <= DIFF_W'(r_err_l) - DIFF_W'(r_last_l);
    end

    // Shared multiplier, one product per cycle.
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_KP_R: begin
                mul_a = INT_W'(r_err_r);
                mul_b = i_cfg.gain_p;
            end
            MUL_KD_R: begin
                mul_a = INT_W'(r_diff_r);
                mul_b = i_cfg.gain_d;
            end
            MUL_KP_L: begin
                mul_a = INT_W'(r_err_l);
                mul_b = i_cfg.gain_p;
            end
            MUL_KD_L: begin
                mul_a = INT_W'(r_diff_l);
                mul_b = i_cfg.gain_d;
            end
            default: begin
                mul_a = r_integ;
                mul_b = i_cfg.gain_i;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.acc_op)
            ACC_LOAD: begin
                r_acc_r <= ACC_W'(r_drive_r);
                r_acc_l <= ACC_W'(r_drive_l);
            end
            ACC_R: r_acc_r <= r_acc_r + ACC_W'(r_prod);
            ACC_L: r_acc_l <= r_acc_l + ACC_W'(r_prod);
            ACC_SYNC: begin
                r_acc_r <= r_acc_r - ACC_W'(r_prod);
                r_acc_l <= r_acc_l + ACC_W'(r_prod);
            end
            default: begin
            end
        endcase
    end

    assign lim_pos = $signed(ACC_W'(r_lim));
    assign lim_neg = -lim_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ   <= '0;
            r_drive_r <= '0;
            r_drive_l <= '0;
            r_last_r  <= '0;
            r_last_l  <= '0;
        end else begin
            if (i_cmd.calc_err) begin
                r_integ <= r_integ + INT_W'(r_pv_r) - INT_W'(r_pv_l) + bias_term;
            end
            if (i_cmd.clamp) begin
                r_last_r <= r_err_r;
                r_last_l <= r_err_l;
                priority if (r_acc_r > lim_pos) r_drive_r <= DRV_W'(lim_pos);
                else if (r_acc_r < lim_neg)     r_drive_r <= DRV_W'(lim_neg);
                else                            r_drive_r <= DRV_W'(r_acc_r);
                priority if (r_acc_l > lim_pos) r_drive_l <= DRV_W'(lim_pos);
                else if (r_acc_l < lim_neg)     r_drive_l <= DRV_W'(lim_neg);
                else                            r_drive_l <= DRV_W'(r_acc_l);
            end
        end
    end

    assign mag_r   = r_drive_r[DRV_W-1] ? -r_drive_r : r_drive_r;
    assign mag_l   = r_drive_l[DRV_W-1] ? -r_drive_l : r_drive_l;
    assign mag_sel = i_cmd.div_left ? mag_l : mag_r;

    dmpsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (DVD_W'(mag_sel[LIM_W-1:0])),
        .i_divisor  (r_div),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // Quotient of a negative drive is negative only when nonzero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_r) begin
            r_q_r <= div_quo;
        end
        if (i_cmd.cap_l) begin
            r_out.right_reverse <= r_drive_r[DRV_W-1] && (r_q_r != '0);
            r_out.right_duty    <= duty_of(r_q_r, r_drive_r[DRV_W-1] && (r_q_r != '0));
            r_out.left_reverse  <= r_drive_l[DRV_W-1] && (div_quo != '0);
            r_out.left_duty     <= duty_of(div_quo, r_drive_l[DRV_W-1] && (div_quo != '0));
        end
    end

    // The output register is only copied out when the outgoing stage is free.
    t_out_item r_hold;
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_hold <= r_out;
        end
    end

    assign o_status.div_done = div_done;
    assign o_out_data        = r_hold;

    a_quo_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cap_r || i_cmd.cap_l) |-> (int'(div_quo) <= DRIVE_LIMIT_STEPS))
        else $error("drive quotient beyond the step limit");

endmodule

[sv/dmpsc_ctrl.sv]
module dmpsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  dmpsc_pkg::t_status  i_status,
    output dmpsc_pkg::t_cmd     o_cmd
);
    import dmpsc_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_ERR       = 4'd1;
    localparam logic [3:0] ST_M1        = 4'd2;
    localparam logic [3:0] ST_M2        = 4'd3;
    localparam logic [3:0] ST_M3        = 4'd4;
    localparam logic [3:0] ST_M4        = 4'd5;
    localparam logic [3:0] ST_M5        = 4'd6;
    localparam logic [3:0] ST_SYNC      = 4'd7;
    localparam logic [3:0] ST_CLAMP     = 4'd8;
    localparam logic [3:0] ST_DIVR_GO   = 4'd9;
    localparam logic [3:0] ST_DIVR_WAIT = 4'd10;
    localparam logic [3:0] ST_DIVL_GO   = 4'd11;
    localparam logic [3:0] ST_DIVL_WAIT = 4'd12;
    localparam logic [3:0] ST_OUT       = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    t_cmd       cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.mul_sel = MUL_KI;
        cmd.acc_op  = ACC_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = ST_ERR;
                end
            end
            ST_ERR: begin
                cmd.calc_err = 1'b1;
                cmd.acc_op   = ACC_LOAD;
                n_state      = ST_M1;
            end
            ST_M1: begin
                cmd.mul_sel = MUL_KP_R;
                n_state     = ST_M2;
            end
            ST_M2: begin
                cmd.mul_sel = MUL_KD_R;
                cmd.acc_op  = ACC_R;
                n_state     = ST_M3;
            end
            ST_M3: begin
                cmd.mul_sel = MUL_KP_L;
                cmd.acc_op  = ACC_R;
                n_state     = ST_M4;
            end
            ST_M4: begin
                cmd.mul_sel = MUL_KD_L;
                cmd.acc_op  = ACC_L;
                n_state     = ST_M5;
            end
            ST_M5: begin
                cmd.mul_sel = MUL_KI;
                cmd.acc_op  = ACC_L;
                n_state     = ST_SYNC;
            end
            ST_SYNC: begin
                cmd.acc_op = ACC_SYNC;
                n_state    = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.clamp = 1'b1;
                n_state   = ST_DIVR_GO;
            end
            ST_DIVR_GO: begin
                cmd.div_start = 1'b1;
                n_state       = ST_DIVR_WAIT;
            end
            ST_DIVR_WAIT: begin
                if (i_status.div_done) begin
                    cmd.cap_r = 1'b1;
                    n_state   = ST_DIVL_GO;
                end
            end
            ST_DIVL_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_left  = 1'b1;
                n_state       = ST_DIVL_WAIT;
            end
            ST_DIVL_WAIT: begin
                if (i_status.div_done) begin
                    cmd.cap_l = 1'b1;
                    n_state   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_out_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> (r_state == ST_IDLE && r_out_valid))
        else $error("finished result not moved to the output register");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("output valid raised outside the output step");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_ERR))
        else $error("accepted request did not start processing");

endmodule

[sv/dual_motor_pd_sync_speed_control.sv]
// Dual motor speed controller: two incremental PD loops tied by a shared
// synchronizing integral of the right-minus-left speed difference.
// Input channel: one request per sample period carrying both encoder counts
// and direction bits; taken when i_in_valid is high and o_in_stall is low.
// Output channel: right/left direction bits and 8-bit PWM duty words, held
// in an output register until taken (o_out_valid high, i_out_stall low).
// Configuration: APB-style writes of target, bias, gains and unit_div at
// byte address 4*index; pready is always high, reads return the register.
// Each request passes through the error step, five passes through the
// shared multiplier, the sync and clamp steps and the shared restoring
// divider, run once per motor; one request is processed at a time, so
// no new request is taken before the last one is through.
// A stalled receiver leaves the result in the output register; the block
// still takes and processes the next request, holding it until the output
// register frees up. Synchronous active-low reset clears the drives, last
// errors, integral and handshake state and restores the register defaults.
module dual_motor_pd_sync_speed_control (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  dmpsc_pkg::t_in_item            i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output dmpsc_pkg::t_out_item           o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dmpsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dmpsc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dmpsc_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);
    import dmpsc_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    dmpsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dmpsc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

    dmpsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

endmodule

[bench/dual_motor_pd_sync_speed_control_test.sv]
module dual_motor_pd_sync_speed_control_test;

    import dmpsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_PCT       = 26;
    localparam int DRAIN_CYCLES   = 40;

    // Addresses that decode to no register.
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    dual_motor_pd_sync_speed_control u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the register file.
    logic signed [TGT_W-1:0]  cfg_target = '0;
    logic signed [TGT_W-1:0]  cfg_bias   = '0;
    logic signed [GAIN_W-1:0] cfg_kp     = 9'sd50;
    logic signed [GAIN_W-1:0] cfg_ki     = 9'sd1;
    logic signed [GAIN_W-1:0] cfg_kd     = 9'sd40;
    logic [DIV_W-1:0]         cfg_div    = 8'd50;

    // Controller state.
    int          right_drive = 0;
    int          left_drive = 0;
    shortint     right_last_err = 0;
    shortint     left_last_err = 0;
    logic [31:0] sync_integ = '0;

    t_in_item    encoder_sample_q[$];
    t_out_item   duty_expect_q[$];
    int          mismatch_count = 0;
    bit          burst_mode = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          idle_cycles = 0;

    function automatic longint clamp_drive(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // {reverse, duty}; quotient truncates toward zero.
    function automatic logic [8:0] drive_to_pwm(longint drive, longint div);
        longint q;
        longint d;
        logic   rev;
        q = drive / div;
        d = q;
        rev = 1'b0;
        if (q < 0) begin
            rev = 1'b1;
            d = 255 + q;
        end
        if (d > 255)
            d = 255;
        if (d < 0)
            d = 0;
        return {rev, d[7:0]};
    endfunction

    function automatic t_out_item pd_sync_update(t_in_item smp);
        longint    target, bias, kp, ki, kd, div, lim;
        longint    spd_r, spd_l, err_r, err_l, dr, dl, integ;
        logic [31:0] step;
        t_out_item res;
        target = longint'(cfg_target);
        bias   = longint'(cfg_bias);
        kp     = longint'(cfg_kp);
        ki     = longint'(cfg_ki);
        kd     = longint'(cfg_kd);
        div    = longint'(cfg_div);
        if (div == 0)
            div = 1;
        lim = DRIVE_LIMIT_STEPS * div;

        spd_r = longint'(smp.right_count);
        if (smp.right_backward)
            spd_r = -spd_r;
        spd_l = longint'(smp.left_count);
        if (smp.left_backward)
            spd_l = -spd_l;

        err_r = target - spd_r;
        err_l = target - spd_l;
        dr = right_drive + kp * err_r + kd * (err_r - right_last_err);
        dl = left_drive + kp * err_l + kd * (err_l - left_last_err);
        right_last_err = shortint'(err_r);
        left_last_err  = shortint'(err_l);

        // bias sign follows the target sign
        step = 32'(spd_r - spd_l + ((target >= 0) ? bias : -bias));
        sync_integ = sync_integ + step;
        integ = longint'($signed(sync_integ));

        dr = clamp_drive(dr - ki * integ, lim);
        dl = clamp_drive(dl + ki * integ, lim);
        right_drive = int'(dr);
        left_drive  = int'(dl);

        {res.right_reverse, res.right_duty} = drive_to_pwm(dr, div);
        {res.left_reverse, res.left_duty}   = drive_to_pwm(dl, div);
        return res;
    endfunction

    // Sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                duty_expect_q.push_back(pd_sync_update(i_in_data));
            if (!i_in_valid || !o_in_stall) begin
                if (encoder_sample_q.size() > 0 &&
                    (burst_mode || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_data  <= encoder_sample_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (duty_expect_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want = duty_expect_q.pop_front();
                    check_field("right_reverse", int'(want.right_reverse),
                                int'(o_out_data.right_reverse));
                    check_field("right_duty", int'(want.right_duty),
                                int'(o_out_data.right_duty));
                    check_field("left_reverse", int'(want.left_reverse),
                                int'(o_out_data.left_reverse));
                    check_field("left_duty", int'(want.left_duty),
                                int'(o_out_data.left_duty));
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !burst_mode && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                     (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TARGET: cfg_target = value[TGT_W-1:0];
            REG_BIAS:   cfg_bias   = value[TGT_W-1:0];
            REG_KP:     cfg_kp     = value[GAIN_W-1:0];
            REG_KI:     cfg_ki     = value[GAIN_W-1:0];
            REG_KD:     cfg_kd     = value[GAIN_W-1:0];
            REG_DIV:    cfg_div    = value[DIV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int target, int bias, int kp, int ki, int kd, int div);
        apb_write(REG_TARGET, target);
        apb_write(REG_BIAS, bias);
        apb_write(REG_KP, kp);
        apb_write(REG_KI, ki);
        apb_write(REG_KD, kd);
        apb_write(REG_DIV, div);
    endtask

    task automatic wait_drained();
        while (encoder_sample_q.size() != 0 || i_in_valid || duty_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_sample(int cr, bit br, int cl, bit bl);
        encoder_sample_q.push_back(t_in_item'{cr[7:0], br, cl[7:0], bl});
    endtask

    // Mostly counts that track the target, so the loops settle instead of
    // pinning at the drive limit; the rest is arbitrary noise.
    function automatic t_in_item tracking_sample();
        t_in_item s;
        int       mag;
        int       cr;
        int       cl;
        bit       rev;
        s.right_count    = 8'($urandom_range(255));
        s.right_backward = 1'($urandom_range(1));
        s.left_count     = 8'($urandom_range(255));
        s.left_backward  = 1'($urandom_range(1));
        if ($urandom_range(99) < 25)
            return s;
        mag = (cfg_target < 0) ? -int'(cfg_target) : int'(cfg_target);
        rev = cfg_target < 0;
        cr = mag + int'($urandom_range(40)) - 20;
        cl = mag + int'($urandom_range(40)) - 20;
        cr = (cr < 0) ? 0 : (cr > 255) ? 255 : cr;
        cl = (cl < 0) ? 0 : (cl > 255) ? 255 : cl;
        s.right_count    = cr[7:0];
        s.left_count     = cl[7:0];
        s.right_backward = ($urandom_range(9) == 0) ? !rev : rev;
        s.left_backward  = ($urandom_range(9) == 0) ? !rev : rev;
        return s;
    endfunction

    initial begin
        int n_items;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: count extremes and direction combinations
        push_sample(0, 0, 0, 0);
        push_sample(255, 0, 255, 0);
        push_sample(255, 1, 255, 1);
        push_sample(255, 0, 0, 0);
        push_sample(0, 0, 255, 1);
        push_sample(1, 1, 1, 0);
        push_sample(170, 1, 85, 0);
        push_sample(85, 0, 170, 1);
        wait_drained();

        write_all(100, 20, 50, 1, 40, 50);
        push_sample(100, 0, 100, 0);
        push_sample(98, 0, 102, 0);
        push_sample(101, 0, 99, 0);
        push_sample(100, 0, 100, 0);
        wait_drained();

        // field extremes, saturating upward
        write_all(4095, -4096, 255, 255, 255, 1);
        push_sample(0, 0, 0, 0);
        push_sample(255, 1, 255, 0);
        push_sample(255, 0, 0, 1);
        wait_drained();

        // opposite extremes, negative target flips the bias
        write_all(-4096, 4095, -256, -256, -256, 255);
        push_sample(0, 0, 0, 0);
        push_sample(255, 1, 255, 0);
        push_sample(255, 0, 0, 1);
        wait_drained();

        // zero divider acts as one; unmapped addresses change nothing
        write_all(-30, 7, 1, 0, 0, 0);
        apb_write(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
        apb_write(REG_UNMAPPED_HI, 32'h0000_1234);
        push_sample(30, 1, 28, 1);
        push_sample(33, 1, 31, 0);
        wait_drained();

        for (int ph = 0; ph < 11; ph++) begin
            if (ph % 4 == 3)
                write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (ph % 2 == 0)
                write_all(int'($urandom_range(600)) - 300, int'($urandom_range(60)) - 30,
                          int'($urandom_range(255)) - 50, int'($urandom_range(10)),
                          int'($urandom_range(255)) - 50, $urandom_range(255, 1));
            else
                write_all(int'($urandom_range(2550)) - 500, int'($urandom_range(2550)) - 500,
                          int'($urandom_range(255)) - 50, int'($urandom_range(255)) - 50,
                          int'($urandom_range(255)) - 50, $urandom_range(255, 1));
            burst_mode = (ph == 2) || (ph == 6);
            n_items = 48;
            if (ph == 6) begin
                // receiver stops long enough for the block to back up its input
                hold_req = 1'b1;
                n_items = 40;
            end
            for (int k = 0; k < n_items; k++)
                encoder_sample_q.push_back(tracking_sample());
            wait_drained();
            burst_mode = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
